[design/sle_pkg.sv]
// Shared types, codes and default sizes for the sequential list engine.
package sle_pkg;

  localparam int unsigned SLE_CAPACITY = 128;

  localparam int unsigned ACT_W     = 4;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CNT_OUT_W = 8;
  localparam int unsigned ST_W      = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT     = 4'd0,
    ACT_DELETE     = 4'd1,
    ACT_READ       = 4'd2,
    ACT_LOCATE     = 4'd3,
    ACT_PUSH_FRONT = 4'd4,
    ACT_POP_FRONT  = 4'd5,
    ACT_PUSH_BACK  = 4'd6,
    ACT_POP_BACK   = 4'd7,
    ACT_CLEAR      = 4'd8
  } act_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // How the datapath will carry out the latched request.
  typedef enum logic [2:0] {
    PLAN_DONE,
    PLAN_OPEN,
    PLAN_CLOSE,
    PLAN_FETCH,
    PLAN_SCAN
  } plan_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_PLAN,
    CMD_OPEN,
    CMD_FETCH,
    CMD_GRAB,
    CMD_CLOSE,
    CMD_SCAN
  } dp_cmd_e;

  typedef struct packed {
    plan_e plan;
    logic  is_close;
    logic  finish;
  } dp_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_OPEN,
    S_FETCH,
    S_GRAB,
    S_CLOSE,
    S_SCAN,
    S_REPLY
  } state_e;

endpackage

[design/sequential_list_engine_unit.sv]
// Top level of the sequential list engine: controller plus datapath.
// Each request is latched when accepted and planned; refusals, clear and unused codes then go
// straight to the result beat. Read fetches one entry; insert and push move entries up, then write
// the value; delete and pop fetch the entry, then move entries down; locate scans to a match or the end.
// Throughput: one item at a time; busy holds from accept until after done_o, and the
// memory (one read, one write port) moves one entry per cycle. The receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the list and idles the controller.
module sequential_list_engine_unit import sle_pkg::*; #(
  parameter int unsigned CAPACITY = SLE_CAPACITY
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [ACT_W-1:0]        action_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    done_o,
  output logic signed [VAL_W-1:0] read_value_o,
  output logic [CNT_OUT_W-1:0]    found_position_o,
  output logic [ST_W-1:0]         status_o,
  output logic [CNT_OUT_W-1:0]    count_o,
  output logic                    is_empty_o
);

  dp_cmd_e cmd;
  dp_sts_t sts;

  // Sequence the request: latch, plan, walk the memory, present the result beat.
  sle_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  // Hold the list, the count and the result registers shown during the beat.
  sle_datapath #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (action_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .read_value_o    (read_value_o),
    .found_position_o(found_position_o),
    .status_o        (status_o),
    .count_o         (count_o),
    .is_empty_o      (is_empty_o)
  );

`ifndef SYNTHESIS
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted beat did not raise busy");

  a_done_in_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result beat outside a busy request");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy && !done_o))
    else $error("result beat longer than one cycle");
`endif

endmodule

[design/sle_ctrl.sv]
// Controller state machine that sequences one list request through the datapath.
module sle_ctrl import sle_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  output logic    done_o,
  output dp_cmd_e cmd_o,
  input  dp_sts_t sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o   = CMD_LATCH;
          state_d = S_PLAN;
        end
      end
      S_PLAN: begin
        cmd_o = CMD_PLAN;
        case (sts_i.plan)
          PLAN_OPEN:  state_d = S_OPEN;
          PLAN_CLOSE: state_d = S_FETCH;
          PLAN_FETCH: state_d = S_FETCH;
          PLAN_SCAN:  state_d = S_SCAN;
          default:    state_d = S_REPLY;
        endcase
      end
      S_OPEN: begin
        cmd_o = CMD_OPEN;
        if (sts_i.finish) state_d = S_REPLY;
      end
      S_FETCH: begin
        cmd_o   = CMD_FETCH;
        state_d = S_GRAB;
      end
      S_GRAB: begin
        cmd_o   = CMD_GRAB;
        state_d = sts_i.is_close ? S_CLOSE : S_REPLY;
      end
      S_CLOSE: begin
        cmd_o = CMD_CLOSE;
        if (sts_i.finish) state_d = S_REPLY;
      end
      S_SCAN: begin
        cmd_o = CMD_SCAN;
        if (sts_i.finish) state_d = S_REPLY;
      end
      S_REPLY: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[design/sle_datapath.sv]
// Datapath: element memory, count, walk pointers and result registers.
module sle_datapath import sle_pkg::*; #(
  parameter int unsigned CAPACITY = SLE_CAPACITY
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_e                 cmd_i,
  output dp_sts_t                 sts_o,
  input  logic [ACT_W-1:0]        action_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic signed [VAL_W-1:0] read_value_o,
  output logic [CNT_OUT_W-1:0]    found_position_o,
  output logic [ST_W-1:0]         status_o,
  output logic [CNT_OUT_W-1:0]    count_o,
  output logic                    is_empty_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Latched request
  act_e                    act_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] val_q;

  // Control state
  logic [CW-1:0] count_q, count_d;
  logic          pend_q, pend_d;

  // Walk state and results
  logic [CW-1:0]           p_q, p_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [AW-1:0]           dst_q, dst_d;
  logic                    close_q, close_d;
  logic signed [VAL_W-1:0] rd_q, rd_d;
  logic [CNT_OUT_W-1:0]    found_q, found_d;
  status_e                 status_q, status_d;

  // Memory
  logic signed [VAL_W-1:0] mem_q [CAPACITY];
  logic signed [VAL_W-1:0] rdata_q;
  logic                    we, re;
  logic [AW-1:0]           wa, ra;
  logic signed [VAL_W-1:0] wd;

  // Plan decode
  plan_e         plan;
  status_e       plan_st;
  logic [CW-1:0] plan_idx;
  logic [CW-1:0] idx_from_pos;
  logic [PW-1:0] pos_w, cnt_w, found_w;
  logic [CW-1:0] p_dec;
  logic          full, empty, match, finish;

  always_comb begin
    pos_w        = PW'(pos_q);
    cnt_w        = PW'(count_q);
    full         = (count_q == CW'(CAPACITY));
    empty        = (count_q == '0);
    idx_from_pos = CW'(pos_w - PW'(1));
    plan         = PLAN_DONE;
    plan_st      = ST_OK;
    plan_idx     = '0;
    case (act_q)
      ACT_INSERT: begin
        if (pos_q == '0 || pos_w > cnt_w + PW'(1)) begin
          plan_st = ST_BAD_POS;
        end else if (full) begin
          plan_st = ST_FULL;
        end else begin
          plan     = PLAN_OPEN;
          plan_idx = idx_from_pos;
        end
      end
      ACT_DELETE, ACT_READ: begin
        if (empty) begin
          plan_st = ST_EMPTY;
        end else if (pos_q == '0 || pos_w > cnt_w) begin
          plan_st = ST_BAD_POS;
        end else begin
          plan     = (act_q == ACT_DELETE) ? PLAN_CLOSE : PLAN_FETCH;
          plan_idx = idx_from_pos;
        end
      end
      ACT_LOCATE: begin
        if (!empty) plan = PLAN_SCAN;
      end
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (full) begin
          plan_st = ST_FULL;
        end else begin
          plan     = PLAN_OPEN;
          plan_idx = (act_q == ACT_PUSH_BACK) ? count_q : '0;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (empty) begin
          plan_st = ST_EMPTY;
        end else begin
          plan     = PLAN_CLOSE;
          plan_idx = (act_q == ACT_POP_BACK) ? count_q - CW'(1) : '0;
        end
      end
      ACT_CLEAR: begin
        plan = PLAN_DONE;
      end
      default: begin
        plan = PLAN_DONE;
      end
    endcase
  end

  always_comb begin
    p_dec   = p_q - CW'(1);
    match   = pend_q && (rdata_q == val_q);
    found_w = PW'(dst_q) + PW'(1);

    count_d  = count_q;
    pend_d   = pend_q;
    p_d      = p_q;
    idx_d    = idx_q;
    dst_d    = dst_q;
    close_d  = close_q;
    rd_d     = rd_q;
    found_d  = found_q;
    status_d = status_q;
    we       = 1'b0;
    wa       = dst_q;
    wd       = rdata_q;
    re       = 1'b0;
    ra       = p_q[AW-1:0];
    finish   = 1'b0;

    case (cmd_i)
      CMD_PLAN: begin
        rd_d     = '0;
        found_d  = '0;
        status_d = plan_st;
        idx_d    = plan_idx;
        close_d  = (plan == PLAN_CLOSE);
        pend_d   = 1'b0;
        case (plan)
          PLAN_OPEN:  p_d = count_q;
          PLAN_CLOSE: p_d = plan_idx + CW'(1);
          default:    p_d = '0;
        endcase
        if (act_q == ACT_CLEAR) count_d = '0;
      end
      CMD_OPEN: begin
        // Move entries up from the top down; the last cycle drops the value in.
        if (pend_q) we = 1'b1;
        if (p_q > idx_q) begin
          re     = 1'b1;
          ra     = p_dec[AW-1:0];
          dst_d  = p_q[AW-1:0];
          pend_d = 1'b1;
          p_d    = p_dec;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            we      = 1'b1;
            wa      = idx_q[AW-1:0];
            wd      = val_q;
            count_d = count_q + CW'(1);
            finish  = 1'b1;
          end
        end
      end
      CMD_FETCH: begin
        re = 1'b1;
        ra = idx_q[AW-1:0];
      end
      CMD_GRAB: begin
        rd_d = rdata_q;
      end
      CMD_CLOSE: begin
        // Move entries down by one, bottom up.
        if (pend_q) we = 1'b1;
        if (p_q < count_q) begin
          re     = 1'b1;
          ra     = p_q[AW-1:0];
          dst_d  = p_dec[AW-1:0];
          pend_d = 1'b1;
          p_d    = p_q + CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - CW'(1);
            finish  = 1'b1;
          end
        end
      end
      CMD_SCAN: begin
        if (match) begin
          found_d = found_w[CNT_OUT_W-1:0];
          pend_d  = 1'b0;
          finish  = 1'b1;
        end else if (p_q < count_q) begin
          re     = 1'b1;
          ra     = p_q[AW-1:0];
          dst_d  = p_q[AW-1:0];
          pend_d = 1'b1;
          p_d    = p_q + CW'(1);
        end else begin
          pend_d = 1'b0;
          finish = !pend_q;
        end
      end
      default: begin
        pend_d = pend_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LATCH) begin
      act_q <= act_e'(action_i);
      pos_q <= position_i;
      val_q <= value_i;
    end
    p_q      <= p_d;
    idx_q    <= idx_d;
    dst_q    <= dst_d;
    close_q  <= close_d;
    rd_q     <= rd_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    if (re) rdata_q <= mem_q[ra];
  end

  assign sts_o.plan     = plan;
  assign sts_o.is_close = close_q;
  assign sts_o.finish   = finish;

  assign read_value_o     = rd_q;
  assign found_position_o = found_q;
  assign status_o         = status_q;
  assign count_o          = cnt_w[CNT_OUT_W-1:0];
  assign is_empty_o       = empty;

endmodule
